// File: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SCL_HIGH_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_LAST_READ  = 2'd1;

	localparam logic [7:0] SCL_HIGH_TICKS_RST = 8'd8;
	localparam logic       ACK_LAST_READ_RST  = 1'b1;

	localparam logic [7:0] ADDR_MASK = 8'hfe;
	localparam logic [7:0] RW_READ   = 8'h01;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_REL    = 5'd1,
		PH_STA_A  = 5'd2,
		PH_STA_B  = 5'd3,
		PH_TX_LO  = 5'd4,
		PH_TX_HI  = 5'd5,
		PH_ACK_LO = 5'd6,
		PH_ACK_HI = 5'd7,
		PH_LOAD   = 5'd8,
		PH_RX_LO  = 5'd9,
		PH_RX_HI  = 5'd10,
		PH_MA_LO  = 5'd11,
		PH_MA_HI  = 5'd12,
		PH_STO_A  = 5'd13,
		PH_STO_B  = 5'd14,
		PH_STO_C  = 5'd15,
		PH_FIN    = 5'd16
	} phase_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_release;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       byte_taken;
		logic       done_res;
		logic       nack;
		logic       busy_res;
	} result_t;

endpackage

// File: src/i2c_master_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_sequencer
// Tick-driven I2C master: write, read or stop-only transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the input channel (in_valid/in_ready) is one bus tick. It
//   carries an optional command (cmd_valid, mode, dev_addr, byte_count,
//   end_with_stop), the next write byte wdata and the sampled SDA level
//   sda_in. Each input beat yields exactly one output beat (out_valid/
//   out_ready) with the SCL/SDA levels to drive and the status flags.
//   A command is taken only on an idle tick; commands while busy are dropped.
//   The output beat is registered and appears in the cycle after its input
//   beat. Throughput: one tick per cycle while the receiver takes each beat;
//   the sequencer state and the result register update in the same cycle.
//   SCL high phases last 1 + scl_high_ticks ticks (not cycles).
//   Stall: when the receiver holds out_ready low, the result register holds
//   its beat and in_ready drops, freezing the sequencer until the beat goes.
//   Reset: phase idle, scl_high_ticks = 8, ack_last_read = 1, no output
//   beat pending; the result register (bus levels) is not reset.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//   ready; write only while idle. Index 0 scl_high_ticks, 1 ack_last_read.
// ----------------------------------------------------------------------------
module i2c_master_sequencer
	import i2cms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// tick input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd_valid,
	input  logic [1:0]           mode,
	input  logic [6:0]           dev_addr,
	input  logic [7:0]           byte_count,
	input  logic                 end_with_stop,
	input  logic [7:0]           wdata,
	input  logic                 sda_in,
	// tick result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl_out,
	output logic                 sda_release,
	output logic [7:0]           read_byte,
	output logic                 read_valid,
	output logic                 byte_taken,
	output logic                 done_res,
	output logic                 nack,
	output logic                 busy_res
);

	// configuration registers
	logic [7:0] scl_high_ticks_q;
	logic       ack_last_read_q;

	// sequencer state
	phase_t     phase_q,        phase_n;
	logic [3:0] bit_index_q,    bit_index_n;
	logic [7:0] bytes_left_q,   bytes_left_n;
	logic [7:0] shift_reg_q,    shift_reg_n;
	logic [7:0] addr_byte_q,    addr_byte_n;
	logic [1:0] op_kind_q,      op_kind_n;
	logic       stop_pending_q, stop_pending_n;
	logic       nack_seen_q,    nack_seen_n;
	logic [7:0] hold_count_q,   hold_count_n;

	// result register
	result_t    res_n, res_q;
	logic       out_valid_q;

	logic       in_fire;
	logic [2:0] bitpos;
	logic       tx_bit;
	logic       ma_sda;
	logic [7:0] rx_shift;

	assign cfg_ready = 1'b1;
	// accept a tick whenever the result slot is free or is drained this cycle
	assign in_ready  = ~out_valid_q | out_ready;
	assign in_fire   = in_valid & in_ready;

	assign bitpos   = 3'd7 - bit_index_q[2:0];
	assign tx_bit   = shift_reg_q[bitpos];
	assign ma_sda   = (bytes_left_q == 8'd1) && !ack_last_read_q;
	assign rx_shift = shift_reg_q | ({7'd0, sda_in} << bitpos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_high_ticks_q <= SCL_HIGH_TICKS_RST;
			ack_last_read_q  <= ACK_LAST_READ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCL_HIGH_TICKS: scl_high_ticks_q <= cfg_data;
				CFG_ACK_LAST_READ:  ack_last_read_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next phase and tick outputs
	always_comb begin
		phase_n        = phase_q;
		bit_index_n    = bit_index_q;
		bytes_left_n   = bytes_left_q;
		shift_reg_n    = shift_reg_q;
		addr_byte_n    = addr_byte_q;
		op_kind_n      = op_kind_q;
		stop_pending_n = stop_pending_q;
		nack_seen_n    = nack_seen_q;
		hold_count_n   = hold_count_q;

		res_n             = '0;
		res_n.scl_out     = 1'b1;
		res_n.sda_release = 1'b1;
		res_n.busy_res    = 1'b1;

		unique case (phase_q)
			PH_IDLE: begin
				res_n.busy_res = 1'b0;
				if (cmd_valid && mode != MODE_NONE) begin
					res_n.busy_res = 1'b1;
					op_kind_n      = mode;
					nack_seen_n    = 1'b0;
					if (mode == MODE_STOP) begin
						stop_pending_n = 1'b1;
						phase_n        = PH_STO_A;
					end else begin
						addr_byte_n    = ({dev_addr, 1'b0} & ADDR_MASK)
							| ((mode == MODE_READ) ? RW_READ : 8'd0);
						bytes_left_n   = byte_count;
						stop_pending_n = end_with_stop;
						phase_n        = PH_REL;
					end
				end
			end
			PH_REL: phase_n = PH_STA_A;
			PH_STA_A: begin
				res_n.sda_release = 1'b0;
				phase_n           = PH_STA_B;
			end
			PH_STA_B: begin
				res_n.sda_release = 1'b0;
				res_n.scl_out     = 1'b0;
				shift_reg_n       = addr_byte_q;
				bit_index_n       = 4'd0;
				phase_n           = PH_TX_LO;
			end
			PH_TX_LO: begin
				res_n.scl_out     = 1'b0;
				res_n.sda_release = tx_bit;
				hold_count_n      = scl_high_ticks_q;
				phase_n           = PH_TX_HI;
			end
			PH_TX_HI: begin
				res_n.sda_release = tx_bit;
				if (hold_count_q != 8'd0) begin
					hold_count_n = hold_count_q - 8'd1;
				end else begin
					bit_index_n = bit_index_q + 4'd1;
					phase_n     = (bit_index_n >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_LO;
				end
			end
			PH_ACK_LO: begin
				res_n.scl_out = 1'b0;
				hold_count_n  = scl_high_ticks_q;
				phase_n       = PH_ACK_HI;
			end
			PH_ACK_HI: begin
				if (hold_count_q != 8'd0) begin
					hold_count_n = hold_count_q - 8'd1;
				end else if (sda_in) begin
					nack_seen_n = 1'b1;
					phase_n     = stop_pending_q ? PH_STO_A : PH_FIN;
				end else if (bytes_left_q == 8'd0) begin
					phase_n = stop_pending_q ? PH_STO_A : PH_FIN;
				end else if (op_kind_q == MODE_READ) begin
					bit_index_n = 4'd0;
					shift_reg_n = 8'd0;
					phase_n     = PH_RX_LO;
				end else begin
					phase_n = PH_LOAD;
				end
			end
			PH_LOAD: begin
				res_n.scl_out    = 1'b0;
				res_n.byte_taken = 1'b1;
				shift_reg_n      = wdata;
				bytes_left_n     = bytes_left_q - 8'd1;
				bit_index_n      = 4'd0;
				phase_n          = PH_TX_LO;
			end
			PH_RX_LO: begin
				res_n.scl_out = 1'b0;
				hold_count_n  = scl_high_ticks_q;
				phase_n       = PH_RX_HI;
			end
			PH_RX_HI: begin
				if (hold_count_q != 8'd0) begin
					hold_count_n = hold_count_q - 8'd1;
				end else begin
					shift_reg_n = rx_shift;
					bit_index_n = bit_index_q + 4'd1;
					if (bit_index_n >= BITS_PER_BYTE) begin
						res_n.read_valid = 1'b1;
						res_n.read_byte  = rx_shift;
						phase_n          = PH_MA_LO;
					end else begin
						phase_n = PH_RX_LO;
					end
				end
			end
			PH_MA_LO: begin
				res_n.scl_out     = 1'b0;
				res_n.sda_release = ma_sda;
				hold_count_n      = scl_high_ticks_q;
				phase_n           = PH_MA_HI;
			end
			PH_MA_HI: begin
				res_n.sda_release = ma_sda;
				if (hold_count_q != 8'd0) begin
					hold_count_n = hold_count_q - 8'd1;
				end else begin
					bytes_left_n = bytes_left_q - 8'd1;
					if (bytes_left_n == 8'd0) begin
						phase_n = stop_pending_q ? PH_STO_A : PH_FIN;
					end else begin
						bit_index_n = 4'd0;
						shift_reg_n = 8'd0;
						phase_n     = PH_RX_LO;
					end
				end
			end
			PH_STO_A: begin
				res_n.scl_out     = 1'b0;
				res_n.sda_release = 1'b0;
				phase_n           = PH_STO_B;
			end
			PH_STO_B: begin
				res_n.sda_release = 1'b0;
				phase_n           = PH_STO_C;
			end
			PH_STO_C: begin
				addr_byte_n    = 8'd0;
				stop_pending_n = 1'b0;
				res_n.done_res = 1'b1;
				res_n.nack     = nack_seen_q;
				phase_n        = PH_IDLE;
			end
			PH_FIN: begin
				// no stop: hold SCL low one more tick and report completion
				res_n.scl_out  = 1'b0;
				res_n.done_res = 1'b1;
				res_n.nack     = nack_seen_q;
				phase_n        = PH_IDLE;
			end
			default: begin
				res_n.busy_res = 1'b0;
				phase_n        = PH_IDLE;
			end
		endcase
	end

	// advance the sequencer only on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_index_q    <= '0;
			bytes_left_q   <= '0;
			shift_reg_q    <= '0;
			addr_byte_q    <= '0;
			op_kind_q      <= '0;
			stop_pending_q <= 1'b0;
			nack_seen_q    <= 1'b0;
			hold_count_q   <= '0;
		end else if (in_fire) begin
			phase_q        <= phase_n;
			bit_index_q    <= bit_index_n;
			bytes_left_q   <= bytes_left_n;
			shift_reg_q    <= shift_reg_n;
			addr_byte_q    <= addr_byte_n;
			op_kind_q      <= op_kind_n;
			stop_pending_q <= stop_pending_n;
			nack_seen_q    <= nack_seen_n;
			hold_count_q   <= hold_count_n;
		end
	end

	// result slot: fill on an accepted tick, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_out     = res_q.scl_out;
	assign sda_release = res_q.sda_release;
	assign read_byte   = res_q.read_byte;
	assign read_valid  = res_q.read_valid;
	assign byte_taken  = res_q.byte_taken;
	assign done_res    = res_q.done_res;
	assign nack        = res_q.nack;
	assign busy_res    = res_q.busy_res;

endmodule

// File: src/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the I2C master sequencer, bound into each sequencer instance.
// ----------------------------------------------------------------------------
module i2cms_checker
	import i2cms_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       scl_out,
	input logic       sda_release,
	input logic [7:0] read_byte,
	input logic       read_valid,
	input logic       byte_taken,
	input logic       done_res,
	input logic       nack,
	input logic       busy_res
);

	// a completion only ever closes a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done_res without busy_res");

	// nack is reported only together with completion
	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nack |-> done_res && busy_res)
		else $error("nack outside a done beat");

	// an idle tick leaves both lines released
	a_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_out && sda_release && !read_valid && !byte_taken)
		else $error("bus driven while idle");

	// a finished read byte appears on an SCL high tick and never with a write fetch
	a_read_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> scl_out && busy_res && !byte_taken && !done_res)
		else $error("read_valid on a wrong tick");

	// a stalled beat holds its contents
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(scl_out)
			&& $stable(sda_release) && $stable(done_res))
		else $error("result changed under stall");

endmodule

bind i2c_master_sequencer i2cms_checker u_i2cms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.scl_out     (scl_out),
	.sda_release (sda_release),
	.read_byte   (read_byte),
	.read_valid  (read_valid),
	.byte_taken  (byte_taken),
	.done_res    (done_res),
	.nack        (nack),
	.busy_res    (busy_res)
);

// File: verif/i2cms_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cms_scoreboard
// Shadows the I2C master sequencer tick by tick and checks every result beat.
// ----------------------------------------------------------------------------
module i2cms_scoreboard
	import i2cms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 cmd_valid,
	input  logic [1:0]           mode,
	input  logic [6:0]           dev_addr,
	input  logic [7:0]           byte_count,
	input  logic                 end_with_stop,
	input  logic [7:0]           wdata,
	input  logic                 sda_in,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 scl_out,
	input  logic                 sda_release,
	input  logic [7:0]           read_byte,
	input  logic                 read_valid,
	input  logic                 byte_taken,
	input  logic                 done_res,
	input  logic                 nack,
	input  logic                 busy_res,
	output int                   errors,
	output int                   pending,
	output phase_t               seq_phase
);

	// shadow sequencer state and register copies
	phase_t     phase;
	logic [3:0] bit_idx;
	logic [7:0] bytes_left;
	logic [7:0] shift_q;
	logic [7:0] addr_byte;
	logic [7:0] hold_left;
	logic [1:0] op_mode;
	logic       stop_pend;
	logic       nack_seen;
	logic [7:0] high_ticks;
	logic       ack_last;

	result_t    expected_q[$];
	result_t    got;
	result_t    want;
	int         beat_no;

	function automatic logic master_ack_level();
		return (bytes_left == 8'd1) && !ack_last;
	endfunction

	function automatic void end_data_phase();
		phase = stop_pend ? PH_STO_A : PH_FIN;
	endfunction

	function automatic void start_high(input phase_t nxt);
		phase = nxt;
		hold_left = high_ticks;
	endfunction

	// advance the shadow by one bus tick and return the levels it drives
	function automatic result_t bus_tick(input logic cv, input logic [1:0] md,
			input logic [6:0] da, input logic [7:0] bc, input logic ews,
			input logic [7:0] wd, input logic sda);
		result_t    r;
		logic [2:0] bp;
		r = '0;
		r.scl_out = 1'b1;
		r.sda_release = 1'b1;
		r.busy_res = 1'b1;
		bp = ~bit_idx[2:0];
		case (phase)
		PH_IDLE: begin
			r.busy_res = 1'b0;
			if (cv && md != MODE_NONE) begin
				r.busy_res = 1'b1;
				op_mode = md;
				nack_seen = 1'b0;
				if (md == MODE_STOP) begin
					stop_pend = 1'b1;
					phase = PH_STO_A;
				end else begin
					addr_byte = ({da, 1'b0} & ADDR_MASK) | ((md == MODE_READ) ? RW_READ : 8'h00);
					bytes_left = bc;
					stop_pend = ews;
					phase = PH_REL;
				end
			end
		end
		PH_REL: phase = PH_STA_A;
		PH_STA_A: begin
			r.sda_release = 1'b0;
			phase = PH_STA_B;
		end
		PH_STA_B: begin
			r.sda_release = 1'b0;
			r.scl_out = 1'b0;
			shift_q = addr_byte;
			bit_idx = '0;
			phase = PH_TX_LO;
		end
		PH_TX_LO: begin
			r.scl_out = 1'b0;
			r.sda_release = shift_q[bp];
			start_high(PH_TX_HI);
		end
		PH_TX_HI: begin
			r.sda_release = shift_q[bp];
			if (hold_left != 8'd0) begin
				hold_left--;
			end else begin
				bit_idx++;
				phase = (bit_idx >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_LO;
			end
		end
		PH_ACK_LO: begin
			r.scl_out = 1'b0;
			start_high(PH_ACK_HI);
		end
		PH_ACK_HI: begin
			if (hold_left != 8'd0) begin
				hold_left--;
			end else if (sda) begin
				nack_seen = 1'b1;
				end_data_phase();
			end else if (bytes_left == 8'd0) begin
				end_data_phase();
			end else if (op_mode == MODE_READ) begin
				bit_idx = '0;
				shift_q = '0;
				phase = PH_RX_LO;
			end else begin
				phase = PH_LOAD;
			end
		end
		PH_LOAD: begin
			r.scl_out = 1'b0;
			r.byte_taken = 1'b1;
			shift_q = wd;
			bytes_left--;
			bit_idx = '0;
			phase = PH_TX_LO;
		end
		PH_RX_LO: begin
			r.scl_out = 1'b0;
			start_high(PH_RX_HI);
		end
		PH_RX_HI: begin
			if (hold_left != 8'd0) begin
				hold_left--;
			end else begin
				shift_q[bp] = shift_q[bp] | sda;
				bit_idx++;
				if (bit_idx >= BITS_PER_BYTE) begin
					r.read_valid = 1'b1;
					r.read_byte = shift_q;
					phase = PH_MA_LO;
				end else begin
					phase = PH_RX_LO;
				end
			end
		end
		PH_MA_LO: begin
			r.scl_out = 1'b0;
			r.sda_release = master_ack_level();
			start_high(PH_MA_HI);
		end
		PH_MA_HI: begin
			r.sda_release = master_ack_level();
			if (hold_left != 8'd0) begin
				hold_left--;
			end else begin
				bytes_left--;
				if (bytes_left == 8'd0) begin
					end_data_phase();
				end else begin
					bit_idx = '0;
					shift_q = '0;
					phase = PH_RX_LO;
				end
			end
		end
		PH_STO_A: begin
			r.scl_out = 1'b0;
			r.sda_release = 1'b0;
			phase = PH_STO_B;
		end
		PH_STO_B: begin
			r.sda_release = 1'b0;
			phase = PH_STO_C;
		end
		PH_STO_C: begin
			addr_byte = '0;
			stop_pend = 1'b0;
			r.done_res = 1'b1;
			r.nack = nack_seen;
			phase = PH_IDLE;
		end
		PH_FIN: begin
			r.scl_out = 1'b0;
			r.done_res = 1'b1;
			r.nack = nack_seen;
			phase = PH_IDLE;
		end
		default: begin
			r.busy_res = 1'b0;
			phase = PH_IDLE;
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("%0t: result beat %0d, %s: got 0x%0h, expected 0x%0h",
			$time, beat_no, what, got_v, want_v);
		errors++;
	endtask

	task automatic cmp_field(input string what, input logic [7:0] got_v,
			input logic [7:0] want_v);
		if (got_v !== want_v)
			report_mismatch(what, int'(got_v), int'(want_v));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			bit_idx = '0;
			bytes_left = '0;
			shift_q = '0;
			addr_byte = '0;
			hold_left = '0;
			op_mode = '0;
			stop_pend = 1'b0;
			nack_seen = 1'b0;
			high_ticks = SCL_HIGH_TICKS_RST;
			ack_last = ACK_LAST_READ_RST;
			expected_q.delete();
			errors = 0;
			beat_no = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_SCL_HIGH_TICKS: high_ticks = cfg_data;
				CFG_ACK_LAST_READ:  ack_last = cfg_data[0];
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_q.push_back(bus_tick(cmd_valid, mode, dev_addr, byte_count,
					end_with_stop, wdata, sda_in));
			if (out_valid && out_ready) begin
				got = {scl_out, sda_release, read_byte, read_valid, byte_taken,
					done_res, nack, busy_res};
				if (expected_q.size() == 0) begin
					report_mismatch("beat with nothing expected", int'(got), 0);
				end else begin
					want = expected_q.pop_front();
					cmp_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
					cmp_field("sda_release", 8'(got.sda_release), 8'(want.sda_release));
					cmp_field("read_byte", got.read_byte, want.read_byte);
					cmp_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
					cmp_field("byte_taken", 8'(got.byte_taken), 8'(want.byte_taken));
					cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
					cmp_field("nack", 8'(got.nack), 8'(want.nack));
					cmp_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
				end
				beat_no++;
			end
		end
		pending = expected_q.size();
		seq_phase = phase;
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Tick-level stimulus for the I2C master sequencer with a responding slave.
// Directed transfers cover the corner cases, then random transfers run under
// four idling patterns; the scoreboard beside the block predicts every beat.
// ----------------------------------------------------------------------------
module tb
	import i2cms_pkg::*;
();

	localparam int     PHASE_TICKS   = 140;   // random ticks per idling phase
	localparam int     HOLD_CYCLES   = 48;    // long receiver hold-off
	localparam int     SETTLE_CYCLES = 8;
	localparam longint LIMIT_NS      = 64'd10_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd_valid;
	logic [1:0]           mode;
	logic [6:0]           dev_addr;
	logic [7:0]           byte_count;
	logic                 end_with_stop;
	logic [7:0]           wdata;
	logic                 sda_in;
	logic                 out_valid;
	logic                 out_ready;
	logic                 scl_out;
	logic                 sda_release;
	logic [7:0]           read_byte;
	logic                 read_valid;
	logic                 byte_taken;
	logic                 done_res;
	logic                 nack;
	logic                 busy_res;

	int     errors;
	int     pending;
	phase_t seq_phase;

	// idling knobs, slave behavior and pressure trigger
	int   gap_pct   = 0;
	int   stall_pct = 0;
	int   nack_at   = -1;
	int   nack_pct  = 0;
	int   ack_cnt   = 0;
	int   tick_cnt  = 0;
	logic hold_trig = 1'b0;

	int   tbl_ticks[4] = '{0, 1, 3, 2};
	int   tbl_ack[4]   = '{0, 1, 0, 1};
	int   tbl_gap[4]   = '{0, 64, 0, 35};
	int   tbl_stall[4] = '{0, 0, 64, 35};

	i2c_master_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd_valid     (cmd_valid),
		.mode          (mode),
		.dev_addr      (dev_addr),
		.byte_count    (byte_count),
		.end_with_stop (end_with_stop),
		.wdata         (wdata),
		.sda_in        (sda_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scl_out       (scl_out),
		.sda_release   (sda_release),
		.read_byte     (read_byte),
		.read_valid    (read_valid),
		.byte_taken    (byte_taken),
		.done_res      (done_res),
		.nack          (nack),
		.busy_res      (busy_res)
	);

	i2cms_scoreboard chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd_valid     (cmd_valid),
		.mode          (mode),
		.dev_addr      (dev_addr),
		.byte_count    (byte_count),
		.end_with_stop (end_with_stop),
		.wdata         (wdata),
		.sda_in        (sda_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scl_out       (scl_out),
		.sda_release   (sda_release),
		.read_byte     (read_byte),
		.read_valid    (read_valid),
		.byte_taken    (byte_taken),
		.done_res      (done_res),
		.nack          (nack),
		.busy_res      (busy_res),
		.errors        (errors),
		.pending       (pending),
		.seq_phase     (seq_phase)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: stall at random per the current phase. On request, hold off
	// for a long stretch so the result register fills and in_ready drops.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_trig) begin
				hold_trig = 1'b0;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Slave side of SDA: answer on the ACK sample, random bits elsewhere.
	// Count the address ACK as number 0 and each write byte ACK after it.
	function automatic logic slave_sda();
		if (seq_phase == PH_ACK_LO)
			ack_cnt++;
		if (seq_phase == PH_ACK_HI)
			return (ack_cnt - 1 == nack_at) || ($urandom_range(0, 99) < nack_pct);
		return 1'($urandom);
	endfunction

	// Offer one tick beat. Idle first at random, then hold valid and the
	// payload until the beat is taken. Enter and leave on a falling edge.
	task automatic send_tick(input logic cv, input logic [1:0] md, input logic [6:0] da,
			input logic [7:0] bc, input logic ews);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd_valid     <= cv;
		mode          <= md;
		dev_addr      <= da;
		byte_count    <= bc;
		end_with_stop <= ews;
		wdata         <= 8'($urandom);
		sda_in        <= slave_sda();
		do @(posedge clk); while (!in_ready);
		tick_cnt++;
		@(negedge clk);
	endtask

	// Idle tick: no command, the other fields random.
	task automatic idle_tick();
		send_tick(1'b0, 2'($urandom_range(0, 3)), 7'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// Issue a command on an idle tick, then keep ticking until the sequencer
	// is back to idle. While busy, drop in stray commands at noise_pct.
	task automatic run_transfer(input logic [1:0] md, input logic [6:0] da,
			input logic [7:0] bc, input logic ews, input int nack_where,
			input int nack_rate, input int noise_pct);
		nack_at  = nack_where;
		nack_pct = nack_rate;
		ack_cnt  = 0;
		send_tick(1'b1, md, da, bc, ews);
		while (seq_phase != PH_IDLE)
			send_tick($urandom_range(0, 99) < noise_pct, 2'($urandom_range(0, 3)),
				7'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// Mostly well-formed writes and reads with short data phases; a few
	// longer ones, stop-only, ignored mode and some noisy slave answers.
	task automatic random_transfer();
		int         pick;
		int         cnt;
		int         where;
		logic [1:0] md;
		pick = $urandom_range(0, 99);
		if (pick < 42)
			md = MODE_WRITE;
		else if (pick < 84)
			md = MODE_READ;
		else if (pick < 93)
			md = MODE_STOP;
		else
			md = MODE_NONE;
		cnt   = ($urandom_range(0, 99) < 4) ? $urandom_range(5, 8) : $urandom_range(0, 4);
		where = ($urandom_range(0, 99) < 25) ? $urandom_range(0, cnt) : -1;
		run_transfer(md, 7'($urandom), 8'(cnt), 1'($urandom), where,
			($urandom_range(0, 99) < 10) ? 30 : 0, 5);
		repeat ($urandom_range(0, 2))
			idle_tick();
	endtask

	// Drop valid and wait until every predicted beat has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int start_cnt;

		// drive every input to a known value and hold reset
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_SCL_HIGH_TICKS;
		cfg_data      = '0;
		in_valid      = 1'b0;
		cmd_valid     = 1'b0;
		mode          = MODE_WRITE;
		dev_addr      = '0;
		byte_count    = '0;
		end_with_stop = 1'b0;
		wdata         = '0;
		sda_in        = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one transfer at the reset settings
		run_transfer(MODE_WRITE, 7'h00, 8'd0, 1'b1, -1, 0, 0);    // address only

		// fastest SCL, final read byte ACKed
		wait_drained();
		write_reg(CFG_SCL_HIGH_TICKS, 8'd0);
		run_transfer(MODE_WRITE, 7'h7f, 8'd2, 1'b0, -1, 0, 0);    // no stop
		run_transfer(MODE_READ, 7'h55, 8'd2, 1'b1, -1, 0, 0);     // last byte ACKed
		run_transfer(MODE_STOP, 7'h2a, 8'd5, 1'b0, -1, 0, 0);     // stop alone
		run_transfer(MODE_NONE, 7'h11, 8'd3, 1'b1, -1, 0, 0);     // ignored mode
		run_transfer(MODE_WRITE, 7'h3c, 8'd3, 1'b1, 0, 0, 0);     // address NACK
		run_transfer(MODE_WRITE, 7'h41, 8'd3, 1'b0, 2, 0, 0);     // data NACK
		run_transfer(MODE_READ, 7'h66, 8'd2, 1'b0, 0, 0, 0);      // read address NACK
		run_transfer(MODE_WRITE, 7'h19, 8'd2, 1'b1, -1, 0, 50);   // commands while busy
		run_transfer(MODE_WRITE, 7'h5a, 8'd255, 1'b1, 1, 0, 0);   // largest count, cut by NACK

		// master NACKs the final read byte
		wait_drained();
		write_reg(CFG_ACK_LAST_READ, 8'd0);
		run_transfer(MODE_READ, 7'h2a, 8'd3, 1'b1, -1, 0, 0);
		run_transfer(MODE_READ, 7'h01, 8'd1, 1'b0, -1, 0, 0);

		// random transfers: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_reg(CFG_SCL_HIGH_TICKS, 8'(tbl_ticks[ph]));
			write_reg(CFG_ACK_LAST_READ, 8'(tbl_ack[ph]));
			gap_pct   = tbl_gap[ph];
			stall_pct = tbl_stall[ph];
			// back-pressure the block while the sender keeps offering beats
			if (ph == 0)
				hold_trig = 1'b1;
			start_cnt = tick_cnt;
			while (tick_cnt - start_cnt < PHASE_TICKS)
				random_transfer();
		end

		// drain, let the pipeline settle, then give the verdict
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
src/i2cms_pkg.sv
src/i2c_master_sequencer.sv
src/i2cms_checker.sv
verif/i2cms_checker.sv
verif/tb.sv
